/* hdl/bitmap_first_fit_allocator_defines.svh */
// Assertion macros for the bitmap first-fit allocator.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bff_pkg.sv */
// Shared types and constants of the bitmap first-fit allocator.
// No dependencies; every module and interface imports this package.
package bff_pkg;

  localparam int unsigned BitmapBytesDef = 64;
  localparam int unsigned BitsPerByte    = 8;
  localparam int unsigned LenW           = 13;
  localparam int unsigned OffW           = 13;
  localparam int unsigned CntW           = 10;
  localparam int unsigned StatusW        = 2;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OOM      = 2'd1,
    STATUS_PAST_END = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MOD_RD,
    ST_MOD_WR,
    ST_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;
    logic load;
    logic scan;
    logic mod_rd;
    logic mod_wr;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic req_free;
    logic req_none;
    logic found;
    logic exhausted;
    logic mod_last;
  } sts_t;

endpackage

/* hdl/bff_req_if.sv */
// Request channel of the bitmap first-fit allocator.
// Depends on bff_pkg for the field widths.
interface bff_req_if import bff_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            op;
  logic [LenW-1:0] byte_length;
  logic [OffW-1:0] byte_offset;

  modport source (output valid, output op, output byte_length, output byte_offset,
                  input ready);
  modport sink   (input valid, input op, input byte_length, input byte_offset,
                  output ready);
endinterface

/* hdl/bff_rsp_if.sv */
// Response channel of the bitmap first-fit allocator.
// Depends on bff_pkg for the field widths.
interface bff_rsp_if import bff_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [OffW-1:0]    region_offset;
  logic [CntW-1:0]    frame_count;

  modport source (output valid, output status, output region_offset,
                  output frame_count, input ready);
  modport sink   (input valid, input status, input region_offset,
                  input frame_count, output ready);
endinterface

/* hdl/bff_ctrl.sv */
// Controller state machine of the bitmap first-fit allocator.
// Depends on bff_pkg; drives the datapath bff_dp through cmd_t and reads sts_t.
module bff_ctrl import bff_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          if (sts_i.req_free) begin
            state_d = sts_i.req_none ? ST_RESP : ST_MOD_RD;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (sts_i.found) begin
          state_d = ST_MOD_RD;
        end else if (sts_i.exhausted) begin
          state_d = ST_RESP;
        end
      end
      ST_MOD_RD: state_d = ST_MOD_WR;
      ST_MOD_WR: begin
        state_d = sts_i.mod_last ? ST_RESP : ST_MOD_RD;
      end
      ST_RESP: begin
        if (!rsp_valid_q || rsp_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR:  cmd_o.clr_we = 1'b1;
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ST_SCAN:   cmd_o.scan   = 1'b1;
      ST_MOD_RD: cmd_o.mod_rd = 1'b1;
      ST_MOD_WR: cmd_o.mod_wr = 1'b1;
      ST_RESP:   cmd_o.out_load = !rsp_valid_q || rsp_ready_i;
      default: begin
        cmd_o       = '0;
        req_ready_o = 1'b0;
      end
    endcase
  end

  // A finished item waits in the output register until it is taken.
  always_comb begin
    if (cmd_o.out_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

/* hdl/bff_dp.sv */
// Datapath of the bitmap first-fit allocator: bitmap memory, run search,
// range masking and result registers. Depends on bff_pkg; steered by bff_ctrl.
module bff_dp import bff_pkg::*; #(
  parameter int unsigned BITMAP_BYTES = BitmapBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  input  logic            op_i,
  input  logic [LenW-1:0] byte_length_i,
  input  logic [OffW-1:0] byte_offset_i,
  output logic [StatusW-1:0] status_o,
  output logic [OffW-1:0]    region_offset_o,
  output logic [CntW-1:0]    frame_count_o
);

  localparam int unsigned AddrW       = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int unsigned FrameW      = AddrW + 3;
  localparam int unsigned CalcW       = ((FrameW > CntW) ? FrameW : CntW) + 1;
  localparam int unsigned TotalFrames = BITMAP_BYTES * BitsPerByte;
  localparam logic [CalcW-1:0] TotalC   = CalcW'(TotalFrames);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(BITMAP_BYTES - 1);

  // Bitmap memory, one byte per row; frame s*8+f is bit f of row s.
  logic [BitsPerByte-1:0] mem_q [BITMAP_BYTES];
  logic                   mem_we, mem_re;
  logic [AddrW-1:0]       mem_wa, mem_ra;
  logic [BitsPerByte-1:0] mem_wd;
  logic [BitsPerByte-1:0] rd_data_q;

  // Scan and clearing state.
  logic [AddrW-1:0]  addr_q;
  logic [AddrW-1:0]  ev_addr_q;
  logic              rd_vld_q, rd_last_q, iss_done_q;
  logic [CntW-1:0]   run_q, run_n;
  logic [FrameW-1:0] start_q, start_n, fstart;
  logic              fnd;

  // Range being marked or cleared.
  logic [AddrW-1:0] mod_addr_q, lo_addr_q, hi_addr_q;
  logic [2:0]       lo_bit_q, hi_bit_q;
  logic             mod_set_q;
  logic [BitsPerByte-1:0] mask;

  // Working result and output registers.
  status_e          status_q, out_status_q;
  logic [OffW-1:0]  region_q, out_region_q;
  logic [CntW-1:0]  need_q, out_count_q;

  // Request decoding for the load cycle.
  logic [CntW-1:0]  need_in;
  logic [CalcW-1:0] free_lo, free_end, free_hi;
  logic             free_past, free_none;
  logic [CalcW-1:0] alloc_lo, alloc_hi, set_lo, set_hi;
  logic             is_free, setup;

  assign is_free   = (op_i == OP_FREE);
  assign need_in   = CntW'(byte_length_i[LenW-1:4]) + CntW'(1);
  assign free_lo   = CalcW'(byte_offset_i[OffW-1:4]);
  assign free_end  = free_lo + CalcW'(need_in);
  assign free_past = free_end > TotalC;
  assign free_none = free_lo >= TotalC;
  assign free_hi   = (free_past ? TotalC : free_end) - CalcW'(1);

  // Walk the eight frames of the byte just read, carrying the run across bytes.
  always_comb begin
    run_n   = run_q;
    start_n = start_q;
    fnd     = 1'b0;
    fstart  = start_q;
    for (int f = 0; f < BitsPerByte; f++) begin
      if (!fnd) begin
        if (!rd_data_q[f]) begin
          if (run_n == '0) start_n = {ev_addr_q, 3'(f)};
          run_n = run_n + CntW'(1);
        end else begin
          run_n = '0;
        end
        if (run_n == need_q) begin
          fnd    = 1'b1;
          fstart = start_n;
        end
      end
    end
  end

  assign alloc_lo = CalcW'(fstart);
  assign alloc_hi = alloc_lo + CalcW'(need_q) - CalcW'(1);

  assign sts_o.clr_last  = (addr_q == LastAddr);
  assign sts_o.req_free  = is_free;
  assign sts_o.req_none  = free_none;
  assign sts_o.found     = cmd_i.scan && rd_vld_q && fnd;
  assign sts_o.exhausted = cmd_i.scan && rd_vld_q && rd_last_q && !fnd;
  assign sts_o.mod_last  = (mod_addr_q == hi_addr_q);

  assign setup  = (cmd_i.load && is_free) || sts_o.found;
  assign set_lo = cmd_i.load ? free_lo : alloc_lo;
  assign set_hi = cmd_i.load ? free_hi : alloc_hi;

  always_comb begin
    for (int f = 0; f < BitsPerByte; f++) begin
      mask[f] = ((mod_addr_q != lo_addr_q) || (3'(f) >= lo_bit_q)) &&
                ((mod_addr_q != hi_addr_q) || (3'(f) <= hi_bit_q));
    end
  end

  // Memory port steering.
  always_comb begin
    mem_we = cmd_i.clr_we || cmd_i.mod_wr;
    mem_wa = cmd_i.clr_we ? addr_q : mod_addr_q;
    if (cmd_i.clr_we) begin
      mem_wd = '0;
    end else if (mod_set_q) begin
      mem_wd = rd_data_q | mask;
    end else begin
      mem_wd = rd_data_q & ~mask;
    end
    mem_re = cmd_i.mod_rd || (cmd_i.scan && !iss_done_q);
    mem_ra = cmd_i.mod_rd ? mod_addr_q : addr_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_data_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      iss_done_q <= 1'b0;
      run_q      <= '0;
      start_q    <= '0;
    end else begin
      if (cmd_i.clr_we) begin
        addr_q <= sts_o.clr_last ? '0 : addr_q + AddrW'(1);
      end else if (cmd_i.load) begin
        addr_q     <= '0;
        rd_vld_q   <= 1'b0;
        iss_done_q <= 1'b0;
        run_q      <= '0;
        start_q    <= '0;
      end else if (cmd_i.scan) begin
        rd_vld_q <= !iss_done_q;
        if (!iss_done_q) begin
          rd_last_q <= (addr_q == LastAddr);
          if (addr_q == LastAddr) begin
            iss_done_q <= 1'b1;
          end else begin
            addr_q <= addr_q + AddrW'(1);
          end
        end
        if (rd_vld_q) begin
          run_q   <= run_n;
          start_q <= start_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) ev_addr_q <= addr_q;
    if (cmd_i.load) begin
      need_q <= need_in;
      if (is_free) begin
        status_q <= free_past ? STATUS_PAST_END : STATUS_OK;
        region_q <= {byte_offset_i[OffW-1:4], 4'b0000};
      end else begin
        status_q <= STATUS_OK;
        region_q <= '0;
      end
    end else if (sts_o.found) begin
      region_q <= OffW'({fstart, 4'b0000});
    end else if (sts_o.exhausted) begin
      status_q <= STATUS_OOM;
    end
    if (setup) begin
      mod_addr_q <= set_lo[AddrW+2:3];
      lo_addr_q  <= set_lo[AddrW+2:3];
      lo_bit_q   <= set_lo[2:0];
      hi_addr_q  <= set_hi[AddrW+2:3];
      hi_bit_q   <= set_hi[2:0];
      mod_set_q  <= !cmd_i.load;
    end else if (cmd_i.mod_wr) begin
      mod_addr_q <= mod_addr_q + AddrW'(1);
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_region_q <= region_q;
      out_count_q  <= need_q;
    end
  end

  assign status_o        = out_status_q;
  assign region_offset_o = out_region_q;
  assign frame_count_o   = out_count_q;

endmodule

/* hdl/bitmap_first_fit_allocator.sv */
// Channel | Dir | Fields                          | Accepted when
// req_i   | in  | op, byte_length, byte_offset    | valid && ready
// rsp_o   | out | status, region_offset, frame_count | valid && ready
//
// After reset the bitmap is zeroed one byte a cycle; no item is accepted until
// then. An allocate scans B bitmap bytes, one per cycle through the single
// memory read port (at most BITMAP_BYTES), and if a run is found reads and
// writes back each of the M bytes the run touches before its result is loaded.
// A free reads and writes back each byte its range touches. A new item is accepted
// while the previous result waits; a stalled output holds the next result back.
//
// Top level of the bitmap first-fit allocator.
// Depends on bff_pkg, bff_req_if, bff_rsp_if, bff_ctrl, bff_dp and the defines header.
`include "bitmap_first_fit_allocator_defines.svh"

module bitmap_first_fit_allocator import bff_pkg::*; #(
  parameter int unsigned BITMAP_BYTES = BitmapBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bff_req_if.sink   req_i,
  bff_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;
  logic req_ready, rsp_valid;

  bff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bff_dp #(
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (req_i.op),
    .byte_length_i   (req_i.byte_length),
    .byte_offset_i   (req_i.byte_offset),
    .status_o        (rsp_o.status),
    .region_offset_o (rsp_o.region_offset),
    .frame_count_o   (rsp_o.frame_count)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;

  // One item is in work at a time.
  `BFF_ASSERT_NEXT(a_one_in_work, req_i.valid && req_i.ready, !req_i.ready, "item accepted while busy")
  // A waiting result is never overwritten.
  `BFF_ASSERT_SAME(a_no_overwrite, cmd.out_load, !rsp_o.valid || rsp_o.ready, "result overwritten")
  // A found run is marked straight away.
  `BFF_ASSERT_NEXT(a_mark_after_find, sts.found, cmd.mod_rd, "found run not marked")

endmodule
